/* hdl/act_pkg.sv */
// act_pkg: sizes, operation codes and shared types of the antenna corner turner.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package act_pkg;

    // array geometry
    localparam int ANTENNAS = 64;
    localparam int CHANNELS = 16;
    localparam int TIMES    = 256;

    // port field widths
    localparam int OP_W     = 2;
    localparam int ANT_W    = 6;
    localparam int CHAN_W   = 4;
    localparam int TIME_W   = 8;
    localparam int SAMPLE_W = 32;

    // internal index widths (at least one bit each)
    localparam int A_IW = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
    localparam int C_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int T_IW = (TIMES > 1) ? $clog2(TIMES) : 1;

    // sample memory: {bank, time, channel, antenna}
    localparam int ADDR_W    = 1 + T_IW + C_IW + A_IW;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    // request queue between front and back, result queue at the output
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
    localparam logic [OP_W-1:0] OP_IDLE  = 2'd2;

    // one memory request from the front
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic [ANT_W-1:0]    antenna;
        logic [CHAN_W-1:0]   channel;
        logic [TIME_W-1:0]   time_idx;
        logic                present;
        logic                last;
        logic                overrun;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [ANT_W-1:0]    antenna;
        logic [CHAN_W-1:0]   channel;
        logic [TIME_W-1:0]   time_idx;
        logic                present;
        logic                last;
        logic                overrun;
    } t_res;

endpackage

/* hdl/act_front.sv */
// act_front: accepts items, tracks banks, presence maps and readout position,
// and turns each item into a memory request. Depends on act_pkg.
`timescale 1ns / 1ps
module act_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [act_pkg::OP_W-1:0]      i_operation,
    input  logic [act_pkg::ANT_W-1:0]     i_antenna,
    input  logic [act_pkg::CHAN_W-1:0]    i_channel,
    input  logic [act_pkg::TIME_W-1:0]    i_time_index,
    input  logic [act_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_cq_full,
    output logic                          o_full,
    output logic                          o_cq_push,
    output act_pkg::t_cmd                 o_cmd
);
    import act_pkg::*;

    logic                r_fill_bank, n_fill_bank;
    logic                r_pending,   n_pending;
    logic                r_overrun,   n_overrun;
    logic [ANTENNAS-1:0] r_present [2];
    logic [ANTENNAS-1:0] n_present [2];
    logic [A_IW-1:0]     r_pa, n_pa;
    logic [C_IW-1:0]     r_pc, n_pc;
    logic [T_IW-1:0]     r_pt, n_pt;

    logic            accept;
    logic            in_range;
    logic            do_write;
    logic            close_ok;
    logic            emit;
    logic            rd_bank;
    logic            last;
    logic [A_IW-1:0] wa;
    logic [C_IW-1:0] wc;
    logic [T_IW-1:0] wt;

    assign o_full = i_cq_full;
    assign accept = i_push && !i_cq_full;

    // decode and index checks
    assign wa       = A_IW'(i_antenna);
    assign wc       = C_IW'(i_channel);
    assign wt       = T_IW'(i_time_index);
    assign in_range = (32'(i_antenna) < 32'(ANTENNAS)) &&
                      (32'(i_channel) < 32'(CHANNELS)) &&
                      (32'(i_time_index) < 32'(TIMES));
    assign do_write = accept && (i_operation == OP_WRITE) && in_range;
    assign close_ok = accept && (i_operation == OP_CLOSE) && !r_pending;
    assign emit     = accept && (r_pending || close_ok);
    // after a swap the read bank is the old fill bank
    assign rd_bank  = close_ok ? r_fill_bank : !r_fill_bank;
    assign last     = (r_pa == A_IW'(ANTENNAS - 1)) && (r_pc == C_IW'(CHANNELS - 1)) &&
                      (r_pt == T_IW'(TIMES - 1));

    // state update
    always_comb begin
        n_fill_bank = r_fill_bank;
        n_pending   = r_pending;
        n_overrun   = r_overrun;
        n_present   = r_present;
        n_pa        = r_pa;
        n_pc        = r_pc;
        n_pt        = r_pt;
        if (do_write) begin
            n_present[r_fill_bank][wa] = 1'b1;
        end
        if (accept && (i_operation == OP_CLOSE) && r_pending) begin
            n_overrun = 1'b1;
        end
        if (close_ok) begin
            n_fill_bank             = !r_fill_bank;
            n_present[!r_fill_bank] = '0;
            n_pending               = 1'b1;
        end
        // readout walk: antenna fastest, time slowest
        if (emit) begin
            if (last) begin
                n_pending = 1'b0;
                n_pa      = '0;
                n_pc      = '0;
                n_pt      = '0;
            end else if (r_pa == A_IW'(ANTENNAS - 1)) begin
                n_pa = '0;
                if (r_pc == C_IW'(CHANNELS - 1)) begin
                    n_pc = '0;
                    n_pt = r_pt + 1'b1;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end else begin
                n_pa = r_pa + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_bank  <= 1'b0;
            r_pending    <= 1'b0;
            r_overrun    <= 1'b0;
            r_present[0] <= '0;
            r_present[1] <= '0;
            r_pa         <= '0;
            r_pc         <= '0;
            r_pt         <= '0;
        end else begin
            r_fill_bank <= n_fill_bank;
            r_pending   <= n_pending;
            r_overrun   <= n_overrun;
            r_present   <= n_present;
            r_pa        <= n_pa;
            r_pc        <= n_pc;
            r_pt        <= n_pt;
        end
    end

    // request toward the back
    assign o_cq_push = do_write || emit;
    always_comb begin
        o_cmd.wr_en    = do_write;
        o_cmd.wr_addr  = {r_fill_bank, wt, wc, wa};
        o_cmd.wr_data  = i_sample;
        o_cmd.rd_en    = emit;
        o_cmd.rd_addr  = {rd_bank, r_pt, r_pc, r_pa};
        o_cmd.antenna  = ANT_W'(r_pa);
        o_cmd.channel  = CHAN_W'(r_pc);
        o_cmd.time_idx = TIME_W'(r_pt);
        o_cmd.present  = r_present[rd_bank][r_pa];
        o_cmd.last     = last;
        o_cmd.overrun  = n_overrun;
    end

endmodule

/* hdl/act_cmd_queue.sv */
// act_cmd_queue: short request queue between front and back.
// Depends on act_pkg.
`timescale 1ns / 1ps
module act_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  act_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output act_pkg::t_cmd o_cmd
);
    import act_pkg::*;

    t_cmd             r_slot [CQ_DEPTH];
    logic [CQ_PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CQ_CW-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CQ_CW'(CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/act_back.sv */
// act_back: sample memory (one write, one read per cycle), read stage and
// result queue toward the output. Depends on act_pkg.
`timescale 1ns / 1ps
module act_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cq_empty,
    input  act_pkg::t_cmd i_cmd,
    output logic          o_cq_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output act_pkg::t_res o_res
);
    import act_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [MEM_DEPTH];

    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    logic [SAMPLE_W-1:0] r_rd_data;

    t_res                r_oq [OQ_DEPTH];
    logic [OQ_PW-1:0]    r_oq_wr, r_oq_rd;
    logic [OQ_CW-1:0]    r_oq_count;

    logic                room;
    logic                issue;
    logic                oq_pop;
    t_res                s1_res;

    // a read may issue only if its result has a slot reserved
    assign room     = ((OQ_CW + 1)'(r_oq_count) + (OQ_CW + 1)'(r_s1_valid)) <
                      (OQ_CW + 1)'(OQ_DEPTH);
    assign issue    = !i_cq_empty && (!i_cmd.rd_en || room);
    assign o_cq_pop = issue;

    // sample memory: the write and the read always hit opposite banks
    always_ff @(posedge i_clk) begin
        if (issue && i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (issue && i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue && i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_cmd <= i_cmd;
        end
    end

    // absent antennas read as zero
    always_comb begin
        s1_res.sample   = r_s1_cmd.present ? r_rd_data : '0;
        s1_res.antenna  = r_s1_cmd.antenna;
        s1_res.channel  = r_s1_cmd.channel;
        s1_res.time_idx = r_s1_cmd.time_idx;
        s1_res.present  = r_s1_cmd.present;
        s1_res.last     = r_s1_cmd.last;
        s1_res.overrun  = r_s1_cmd.overrun;
    end

    // result queue
    assign o_empty = (r_oq_count == '0);
    assign oq_pop  = i_pop && !o_empty;
    assign o_res   = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            if (r_s1_valid) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            if (r_s1_valid && !oq_pop) begin
                r_oq_count <= r_oq_count + 1'b1;
            end else if (oq_pop && !r_s1_valid) begin
                r_oq_count <= r_oq_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_oq_wr] <= s1_res;
        end
    end

endmodule

/* hdl/antenna_corner_turn_top.sv */
// antenna_corner_turn_top: double-buffered corner turner, top level.
// Instantiates act_front, act_cmd_queue and act_back; depends on act_pkg.
//
// Usage:
//   Input side is a queue write port: an item is taken on a rising edge
//   with push high and full low. Operation write stores a sample in the
//   fill bank and marks its antenna present; close swaps banks and starts
//   readout of the closed frame; idle (and the unused code) only advances
//   readout. A close during readout is dropped and sets the sticky overrun.
//   Result side is a queue read port: while empty is low the oldest word
//   is on the o_ ports, and it is taken on an edge with pop high.
//   Every item taken while readout runs (the starting close too) yields
//   one word, antenna fastest, then channel, then time.
//   A word's request passes the request queue, the read stage and the result queue in order.
//   Throughput: one item per cycle while full stays low, set by the single write and single
//   read port of the sample memory.
//   When pop stays low the result queue (4 words) and the request queue
//   (4 requests) fill, then full rises until words are taken.
//   Reset (synchronous, active low) empties both queues, clears presence
//   maps, bank select, readout state and overrun; memory is not cleared.
`timescale 1ns / 1ps
module antenna_corner_turn_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [act_pkg::OP_W-1:0]      i_operation,
    input  logic [act_pkg::ANT_W-1:0]     i_antenna,
    input  logic [act_pkg::CHAN_W-1:0]    i_channel,
    input  logic [act_pkg::TIME_W-1:0]    i_time_index,
    input  logic [act_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [act_pkg::SAMPLE_W-1:0]  o_out_sample,
    output logic [act_pkg::ANT_W-1:0]     o_out_antenna,
    output logic [act_pkg::CHAN_W-1:0]    o_out_channel,
    output logic [act_pkg::TIME_W-1:0]    o_out_time,
    output logic                          o_antenna_present,
    output logic                          o_frame_last,
    output logic                          o_overrun
);
    import act_pkg::*;

    logic cq_push, cq_full, cq_pop, cq_empty;
    t_cmd cmd_in, cmd_out;
    t_res res;

    // front: decode and bookkeeping
    act_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_operation  (i_operation),
        .i_antenna    (i_antenna),
        .i_channel    (i_channel),
        .i_time_index (i_time_index),
        .i_sample     (i_sample),
        .i_cq_full    (cq_full),
        .o_full       (full),
        .o_cq_push    (cq_push),
        .o_cmd        (cmd_in)
    );

    // request queue
    act_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_cmd   (cmd_in),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_empty (cq_empty),
        .o_cmd   (cmd_out)
    );

    // back: memory and result queue
    act_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cq_empty (cq_empty),
        .i_cmd      (cmd_out),
        .o_cq_pop   (cq_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_out_sample      = res.sample;
    assign o_out_antenna     = res.antenna;
    assign o_out_channel     = res.channel;
    assign o_out_time        = res.time_idx;
    assign o_antenna_present = res.present;
    assign o_frame_last      = res.last;
    assign o_overrun         = res.overrun;

    // front never pushes into a full request queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cq_push |-> !cq_full)
        else $error("request pushed into full queue");

    // reset leaves no result pending
    assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible after reset");

    // last word of a frame sits at the final position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_last) |->
            (o_out_antenna == ANT_W'(ANTENNAS - 1)) &&
            (o_out_channel == CHAN_W'(CHANNELS - 1)) &&
            (o_out_time == TIME_W'(TIMES - 1)))
        else $error("frame end at wrong position");

    // absent antenna reads as zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_antenna_present) |-> (o_out_sample == '0))
        else $error("absent antenna gave nonzero word");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for antenna_corner_turn_top (queue-style push/pop ports).
// Predicts every readout word from its own copy of both banks; depends on act_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
    import act_pkg::*;

    localparam int FRAME_WORDS = ANTENNAS * CHANNELS * TIMES;
    // unused operation code, handled as an idle tick
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    // sized for worst-case sender gaps, receiver stalls and pipeline delay per request
    // over roughly 1500 requests, with a wide margin
    localparam longint CYCLE_LIMIT = 1_000_000;
    // time rows written per present antenna; the readout in this run stays
    // below PRESET_TIMES * ANTENNAS * CHANNELS words, so no unwritten entry is read
    localparam int PRESET_TIMES = 2;
    localparam int RAND_REQS = 1100;
    localparam int QUIET_REQS = 300;
    localparam int REQ_Q_MAX = 256;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ANT_W-1:0]    ant;
        logic [CHAN_W-1:0]   chan;
        logic [TIME_W-1:0]   tidx;
        logic [SAMPLE_W-1:0] smp;
    } t_turn_req;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [OP_W-1:0]     i_operation = '0;
    logic [ANT_W-1:0]    i_antenna = '0;
    logic [CHAN_W-1:0]   i_channel = '0;
    logic [TIME_W-1:0]   i_time_index = '0;
    logic [SAMPLE_W-1:0] i_sample = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [SAMPLE_W-1:0] o_out_sample;
    logic [ANT_W-1:0]    o_out_antenna;
    logic [CHAN_W-1:0]   o_out_channel;
    logic [TIME_W-1:0]   o_out_time;
    logic                o_antenna_present;
    logic                o_frame_last;
    logic                o_overrun;

    antenna_corner_turn_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_operation       (i_operation),
        .i_antenna         (i_antenna),
        .i_channel         (i_channel),
        .i_time_index      (i_time_index),
        .i_sample          (i_sample),
        .empty             (empty),
        .pop               (pop),
        .o_out_sample      (o_out_sample),
        .o_out_antenna     (o_out_antenna),
        .o_out_channel     (o_out_channel),
        .o_out_time        (o_out_time),
        .o_antenna_present (o_antenna_present),
        .o_frame_last      (o_frame_last),
        .o_overrun         (o_overrun)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Corner-turn predictor: both banks, presence maps, readout pointer
    // ------------------------------------------------------------------
    bit [SAMPLE_W-1:0] bank_mem [0:2*FRAME_WORDS-1];
    bit [ANTENNAS-1:0] ant_seen [0:1];
    bit                fill_sel = 1'b0;
    bit                draining = 1'b0;
    bit                ovr_seen = 1'b0;
    int unsigned       drain_pos = 0;
    t_res              turned_q[$];

    function automatic int unsigned word_addr(input bit bank, input int unsigned a,
                                              input int unsigned c, input int unsigned t);
        return (bank ? FRAME_WORDS : 0) + (t * CHANNELS + c) * ANTENNAS + a;
    endfunction

    task automatic turn_item(input t_turn_req r);
        t_res        w;
        bit          rb;
        int unsigned pa, pc, pt;
        unique case (r.op)
            OP_WRITE: begin
                bank_mem[word_addr(fill_sel, r.ant, r.chan, r.tidx)] = r.smp;
                ant_seen[fill_sel][r.ant] = 1'b1;
            end
            OP_CLOSE: begin
                if (draining) begin
                    ovr_seen = 1'b1;
                end else begin
                    fill_sel = !fill_sel;
                    ant_seen[fill_sel] = '0;
                    draining = 1'b1;
                    drain_pos = 0;
                end
            end
            default: ;
        endcase
        // one word of the closed bank per request while draining
        if (draining) begin
            rb = !fill_sel;
            pa = drain_pos % ANTENNAS;
            pc = (drain_pos / ANTENNAS) % CHANNELS;
            pt = drain_pos / (ANTENNAS * CHANNELS);
            w.present  = ant_seen[rb][pa];
            w.sample   = w.present ? bank_mem[word_addr(rb, pa, pc, pt)] : '0;
            w.antenna  = pa[ANT_W-1:0];
            w.channel  = pc[CHAN_W-1:0];
            w.time_idx = pt[TIME_W-1:0];
            w.last     = (drain_pos + 1 >= FRAME_WORDS);
            w.overrun  = ovr_seen;
            turned_q.push_back(w);
            if (w.last) begin
                draining = 1'b0;
                drain_pos = 0;
            end else begin
                drain_pos++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Request generator
    // ------------------------------------------------------------------
    t_turn_req req_q[$];
    bit        ovr_ok = 1'b0;
    bit        quiet = 1'b0;

    task automatic send(input logic [OP_W-1:0] op, input int a, input int c, input int t,
                        input logic [SAMPLE_W-1:0] s);
        t_turn_req r;
        r.op   = op;
        r.ant  = a[ANT_W-1:0];
        r.chan = c[CHAN_W-1:0];
        r.tidx = t[TIME_W-1:0];
        r.smp  = s;
        while (req_q.size() >= REQ_Q_MAX) @(posedge i_clk);
        req_q.push_back(r);
    endtask

    // every channel of the first time rows of one antenna
    task automatic fill_rows(input int a);
        for (int t = 0; t < PRESET_TIMES; t++)
            for (int c = 0; c < CHANNELS; c++)
                send(OP_WRITE, a, c, t, $urandom);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // the fill bank is not read back within the run, any index will do
            send(OP_WRITE, $urandom_range(0, ANTENNAS - 1), $urandom_range(0, CHANNELS - 1),
                 $urandom_range(0, TIMES - 1), $urandom);
        end else if (pick < 97 || !ovr_ok) begin
            send(pick < 80 ? OP_IDLE : OP_SPARE, $urandom_range(0, ANTENNAS - 1),
                 $urandom_range(0, CHANNELS - 1), $urandom_range(0, TIMES - 1), $urandom);
        end else begin
            // close while draining
            send(OP_CLOSE, $urandom_range(0, ANTENNAS - 1), $urandom_range(0, CHANNELS - 1),
                 $urandom_range(0, TIMES - 1), $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one request on the bus until taken, random gaps between
    // ------------------------------------------------------------------
    t_turn_req cur_req = '0;
    bit        have_req = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    always @(posedge i_clk) begin
        if (push && !full) begin
            turn_item(cur_req);
            have_req = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !have_req) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (req_q.size() > 0) begin
                if (!quiet && $urandom_range(0, 31) == 0) begin
                    send_gap = $urandom_range(1, 15);
                end else begin
                    cur_req = req_q.pop_front();
                    have_req = 1'b1;
                end
            end
        end
        push         <= have_req;
        i_operation  <= cur_req.op;
        i_antenna    <= cur_req.ant;
        i_channel    <= cur_req.chan;
        i_time_index <= cur_req.tidx;
        i_sample     <= cur_req.smp;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 31) == 0) begin
            recv_gap = $urandom_range(0, 14);
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each popped word with the oldest prediction
    // ------------------------------------------------------------------
    int err_cnt = 0;

    always @(posedge i_clk) begin : word_check
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (turned_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%0t: unexpected word ant %0d ch %0d t %0d sample %h", $realtime,
                             o_out_antenna, o_out_channel, o_out_time, o_out_sample);
            end else begin
                want = turned_q.pop_front();
                if (o_out_sample !== want.sample || o_out_antenna !== want.antenna ||
                    o_out_channel !== want.channel || o_out_time !== want.time_idx ||
                    o_antenna_present !== want.present || o_frame_last !== want.last ||
                    o_overrun !== want.overrun) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("%0t: mismatch exp ant %0d ch %0d t %0d smp %h pres %b last %b ovr %b",
                                 $realtime, want.antenna, want.channel, want.time_idx,
                                 want.sample, want.present, want.last, want.overrun);
                        $display("            got ant %0d ch %0d t %0d smp %h pres %b last %b ovr %b",
                                 o_out_antenna, o_out_channel, o_out_time, o_out_sample,
                                 o_antenna_present, o_frame_last, o_overrun);
                    end
                end
            end
        end
    end

    // watchdog
    longint cycle_cnt = 0;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence and end of run
    // ------------------------------------------------------------------
    initial begin
        // frame 1 into bank 0: first time rows of antennas 0, 21 and 63
        fill_rows(0);
        fill_rows(21);
        fill_rows(ANTENNAS - 1);

        // field extremes and every operation code but close, nothing drains yet
        send(OP_WRITE, ANTENNAS - 1, CHANNELS - 1, TIMES - 1, '1);
        send(OP_WRITE, 0, 0, 0, '0);
        send(OP_WRITE, 0, CHANNELS - 1, 0, 32'h8000_0001);
        send(OP_WRITE, ANTENNAS - 1, 0, TIMES - 1, 32'h7fff_fffe);
        send(OP_IDLE, ANTENNAS - 1, CHANNELS - 1, TIMES - 1, '1);
        send(OP_IDLE, 0, 0, 0, '0);
        send(OP_SPARE, 0, 0, 0, '0);
        send(OP_SPARE, ANTENNAS - 1, CHANNELS - 1, TIMES - 1, '1);

        // close swaps banks and yields the first word itself
        send(OP_CLOSE, 0, 0, 0, '0);
        send(OP_IDLE, 0, 0, 0, '0);
        send(OP_SPARE, ANTENNAS - 1, CHANNELS - 1, TIMES - 1, '1);

        // bank 1 fills while bank 0 drains
        repeat (RAND_REQS / 2) random_item();

        // close during readout: dropped, overrun goes sticky
        send(OP_CLOSE, ANTENNAS - 1, CHANNELS - 1, TIMES - 1, '1);
        ovr_ok = 1'b1;
        repeat (RAND_REQS / 2) random_item();

        // closing stretch without idling on either side
        quiet = 1'b1;
        repeat (QUIET_REQS) random_item();

        while (req_q.size() != 0 || have_req) @(posedge i_clk);
        while (turned_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
